// ===== rtl/jft_pkg.sv =====
// Package for the Johnson curve forward transform.
// Holds widths, the ln2 constant, register and status codes, and the
// structures that travel between the pipeline cells. No dependencies.
package jft_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int LOG_FRAC = 30;
   localparam int WIDE_BITS = WORD_BITS + 3;
   localparam int VAL_BITS = WORD_BITS + 2;
   localparam int K_BITS = 6;
   localparam int MANT_BITS = LOG_FRAC + 1;
   localparam int HALF_BITS = WORD_BITS - 1;
   localparam int SQ_BITS = 2 * WORD_BITS;
   localparam int ROOT_BITS = WORD_BITS;
   localparam int SQRT_STEPS = WORD_BITS;
   localparam int LOG_STEPS = LOG_FRAC;
   localparam int MAG_BITS = K_BITS + LOG_FRAC;
   localparam int LN_BITS = MAG_BITS;
   localparam int LN_SUM_BITS = 32 + LN_BITS;
   localparam int PROD_BITS = 40;
   localparam int Q_SUM_BITS = LN_SUM_BITS + 2;
   localparam int Z_BITS = PROD_BITS + 2;
   localparam int CSR_IDX_BITS = 3;
   localparam int FRONT_STAGES = 4;
   localparam int PIPE_DEPTH = FRONT_STAGES + SQRT_STEPS + 3 + LOG_STEPS + 1 + 4 + 1;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef enum logic [1:0] {
      FAM_NONE = 2'd0,
      FAM_SB   = 2'd1,
      FAM_SL   = 2'd2,
      FAM_SU   = 2'd3
   } family_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_SAT   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FAMILY = 3'd0,
      CSR_SHIFT  = 3'd1,
      CSR_SCALE  = 3'd2,
      CSR_GAMMA  = 3'd3,
      CSR_ETA    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                ok;
      logic                neg;
      logic                sh;
      logic [VAL_BITS-1:0] va;
      logic [VAL_BITS-1:0] vb;
   } front_type;

   typedef struct packed {
      logic [SQ_BITS-1:0] rem;
      logic [SQ_BITS-1:0] root;
      logic [SQ_BITS-1:0] probe;
   } sqrt_state_type;

   typedef struct packed {
      logic [MANT_BITS-1:0] m;
      logic [K_BITS-1:0]    k;
      logic [LOG_FRAC-1:0]  frac;
   } log_lane_type;

   typedef struct packed {
      log_lane_type lane_a;
      log_lane_type lane_b;
      logic         ok;
      logic         neg;
   } log_state_type;

endpackage

// ===== rtl/jft_sqrt_cell.sv =====
// One step of the integer square root chain.
// Depends on jft_pkg for the cell state and side data structures.
module jft_sqrt_cell (
   input  logic                    clock,
   input  logic                    en,
   input  jft_pkg::sqrt_state_type up_state,
   input  jft_pkg::front_type      up_side,
   output jft_pkg::sqrt_state_type dn_state,
   output jft_pkg::front_type      dn_side
);
   import jft_pkg::*;

   logic [SQ_BITS-1:0] trial;
   sqrt_state_type     state_in;
   sqrt_state_type     state_ff;
   front_type          side_ff;

   always_comb begin
      trial = up_state.root + up_state.probe;
      state_in.probe = up_state.probe >> 2;
      if (up_state.rem >= trial) begin
         state_in.rem = up_state.rem - trial;
         state_in.root = (up_state.root >> 1) + up_state.probe;
      end else begin
         state_in.rem = up_state.rem;
         state_in.root = up_state.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
         side_ff <= up_side;
      end
   end

   assign dn_state = state_ff;
   assign dn_side = side_ff;

endmodule

// ===== rtl/jft_log_cell.sv =====
// One fraction bit of the two base-2 logarithm lanes.
// Depends on jft_pkg for the lane structures and widths.
module jft_log_cell (
   input  logic                   clock,
   input  logic                   en,
   input  jft_pkg::log_state_type up_state,
   output jft_pkg::log_state_type dn_state
);
   import jft_pkg::*;

   log_state_type state_in;
   log_state_type state_ff;

   function automatic log_lane_type lane_step(log_lane_type cur);
      logic [2*MANT_BITS-1:0] sq;
      logic [MANT_BITS:0]     top;
      log_lane_type           nxt;
      sq = (2*MANT_BITS)'(cur.m) * (2*MANT_BITS)'(cur.m);
      top = sq[2*MANT_BITS-1:LOG_FRAC];
      nxt.k = cur.k;
      nxt.frac = {cur.frac[LOG_FRAC-2:0], top[MANT_BITS]};
      nxt.m = top[MANT_BITS] ? top[MANT_BITS:1] : top[MANT_BITS-1:0];
      return nxt;
   endfunction

   always_comb begin
      state_in.lane_a = lane_step(up_state.lane_a);
      state_in.lane_b = lane_step(up_state.lane_b);
      state_in.ok = up_state.ok;
      state_in.neg = up_state.neg;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

   assign dn_state = state_ff;

endmodule

// ===== rtl/jft_scale.sv =====
// Back end: ln2 conversion, eta scaling, gamma offset and saturation.
// Depends on jft_pkg; its last registers are the response registers.
module jft_scale (
   input  logic                               clock,
   input  logic                               en,
   input  logic [jft_pkg::MAG_BITS-1:0]       mag,
   input  logic                               neg,
   input  logic                               ok,
   input  logic signed [jft_pkg::WORD_BITS-1:0] gamma,
   input  logic [jft_pkg::WORD_BITS-1:0]      eta,
   output logic signed [jft_pkg::WORD_BITS-1:0] score,
   output jft_pkg::status_type                status
);
   import jft_pkg::*;

   localparam int HI_BITS = MAG_BITS - 32;

   logic [63:0]                plo_ff, plo_in;
   logic [HI_BITS+31:0]        phi_ff, phi_in;
   logic [LN_SUM_BITS-1:0]     ln_sum;
   logic [LN_BITS-1:0]         ln_ff, ln_in;
   logic [63:0]                qlo_ff, qlo_in;
   logic [HI_BITS+31:0]        qhi_ff, qhi_in;
   logic [Q_SUM_BITS-1:0]      q_sum;
   logic [PROD_BITS-1:0]       prod_ff, prod_in;
   logic [3:0]                 neg_ff, ok_ff;
   logic signed [Z_BITS-1:0]   z;
   logic [Z_BITS-1:0]          term;
   logic signed [WORD_BITS-1:0] score_ff, score_in;
   status_type                 status_ff, status_in;

   always_comb begin
      plo_in = 64'(mag[31:0]) * 64'(LN2_Q32);
      phi_in = (HI_BITS+32)'(mag[MAG_BITS-1:32]) * (HI_BITS+32)'(LN2_Q32);
      ln_sum = LN_SUM_BITS'(plo_ff) + (LN_SUM_BITS'(phi_ff) << 32)
             + (LN_SUM_BITS'(1) << 31);
      ln_in = ln_sum[32 +: LN_BITS];
      qlo_in = 64'(ln_ff[31:0]) * 64'(eta);
      qhi_in = (HI_BITS+32)'(ln_ff[LN_BITS-1:32]) * (HI_BITS+32)'(eta);
      q_sum = Q_SUM_BITS'(qlo_ff) + (Q_SUM_BITS'(qhi_ff) << 32)
            + (Q_SUM_BITS'(1) << (LOG_FRAC - 1));
      prod_in = q_sum[LOG_FRAC +: PROD_BITS];
      term = neg_ff[3] ? Z_BITS'(0) - Z_BITS'(prod_ff) : Z_BITS'(prod_ff);
      z = Z_BITS'(gamma) + term;
      if (!ok_ff[3]) begin
         score_in = '0;
         status_in = STAT_RANGE;
      end else if (z[Z_BITS-1:WORD_BITS-1] != '0 && z[Z_BITS-1:WORD_BITS-1] != '1) begin
         score_in = z[Z_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                : {1'b0, {(WORD_BITS-1){1'b1}}};
         status_in = STAT_SAT;
      end else begin
         score_in = z[WORD_BITS-1:0];
         status_in = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         ln_ff <= ln_in;
         qlo_ff <= qlo_in;
         qhi_ff <= qhi_in;
         prod_ff <= prod_in;
         neg_ff <= {neg_ff[2:0], neg};
         ok_ff <= {ok_ff[2:0], ok};
         score_ff <= score_in;
         status_ff <= status_in;
      end
   end

   assign score = score_ff;
   assign status = status_ff;

endmodule

// ===== rtl/johnson_forward_transform.sv =====
// Top level of the Johnson curve forward transform.
// Depends on jft_pkg, jft_sqrt_cell, jft_log_cell and jft_scale.
//
// Each request carries one signed Q16.16 sample on req_sample_in. The block
// answers every request with one response holding the normal score
// rsp_score_out and rsp_status_out (ok, outside support, saturated).
// Requests and responses use valid and ready; the csr_ port writes the five
// curve registers and may only be written while no request is in flight.
// The datapath is one flat pipeline: a front end, a row of 32 square root
// cells, normalization, a row of 30 logarithm cells with two lanes each, and
// a multiply back end. One request is taken every cycle while the receiver is
// ready. When the receiver stalls, the whole pipeline holds and req_ready
// drops, and the pending response stays stable on the rsp_ ports. Reset
// empties the pipeline and loads the register defaults: no family, zero
// shift, unit scale, zero gamma and unit eta.
module johnson_forward_transform (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [jft_pkg::WORD_BITS-1:0]  req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [jft_pkg::WORD_BITS-1:0]  rsp_score_out,
   output logic [1:0]                            rsp_status_out,
   input  logic                                  csr_we,
   input  logic [jft_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [jft_pkg::WORD_BITS-1:0]         csr_wdata
);
   import jft_pkg::*;

   logic                        en;
   logic [PIPE_DEPTH-1:0]       vld_ff, vld_in;

   family_type                  family_ff;
   logic signed [WORD_BITS-1:0] shift_ff;
   logic [WORD_BITS-1:0]        scale_ff;
   logic signed [WORD_BITS-1:0] gamma_ff;
   logic [WORD_BITS-1:0]        eta_ff;
   logic                        is_su;

   logic signed [WORD_BITS-1:0] x_ff;
   logic signed [WIDE_BITS-1:0] xw, ew, lw, diff, right, dabs;
   logic                        diff_pos, right_pos;
   front_type                   front_in, front_ff, side2_ff;
   logic [HALF_BITS-1:0]        dh_in, lh_in, dh_ff, lh_ff;
   logic [2*HALF_BITS-1:0]      sqa_ff, sqb_ff;
   sqrt_state_type              sq_st [0:SQRT_STEPS];
   front_type                   sq_side [0:SQRT_STEPS];

   logic [VAL_BITS-1:0]         hyp, va_h_in, va_h_ff, vb_h_ff;
   logic [1:0]                  h_flag_ff;
   logic [VAL_BITS-1:0]         va_n_ff, vb_n_ff;
   logic [K_BITS-1:0]           ka_ff, kb_ff;
   logic [1:0]                  n_flag_ff;
   log_state_type               log_st [0:LOG_STEPS];

   logic [MAG_BITS-1:0]         la, lb;
   logic [MAG_BITS:0]           a2, a2_abs;
   logic [MAG_BITS-1:0]         mag_ff;
   logic                        sgn_ff, ok_d_ff;

   function automatic logic [K_BITS-1:0] lead_one(logic [VAL_BITS-1:0] v);
      logic [K_BITS-1:0] pos;
      pos = '0;
      for (int i = 0; i < VAL_BITS; i++) begin
         if (v[i]) begin
            pos = K_BITS'(i);
         end
      end
      return pos;
   endfunction

   function automatic logic [MANT_BITS-1:0] norm_mant(logic [VAL_BITS-1:0] v,
                                                      logic [K_BITS-1:0] k);
      logic [MANT_BITS-1:0] m;
      if (k >= K_BITS'(LOG_FRAC)) begin
         m = MANT_BITS'(v >> (k - K_BITS'(LOG_FRAC)));
      end else begin
         m = MANT_BITS'(v << (K_BITS'(LOG_FRAC) - k));
      end
      return m;
   endfunction

   assign en = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_valid};
   assign is_su = (family_ff == FAM_SU);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff <= FAM_NONE;
         shift_ff <= '0;
         scale_ff <= WORD_BITS'(1) << FRAC_BITS;
         gamma_ff <= '0;
         eta_ff <= WORD_BITS'(1) << FRAC_BITS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FAMILY: family_ff <= family_type'(csr_wdata[1:0]);
            CSR_SHIFT:  shift_ff <= csr_wdata;
            CSR_SCALE:  scale_ff <= csr_wdata;
            CSR_GAMMA:  gamma_ff <= csr_wdata;
            CSR_ETA:    eta_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      xw = WIDE_BITS'(x_ff);
      ew = WIDE_BITS'(shift_ff);
      lw = WIDE_BITS'({1'b0, scale_ff});
      diff = xw - ew;
      right = ew + lw - xw;
      diff_pos = !diff[WIDE_BITS-1] && (diff != '0);
      right_pos = !right[WIDE_BITS-1] && (right != '0);
      dabs = diff[WIDE_BITS-1] ? -diff : diff;
      front_in.neg = diff[WIDE_BITS-1];
      front_in.sh = (dabs[WIDE_BITS-1:WORD_BITS-1] != '0) || scale_ff[WORD_BITS-1];
      dh_in = HALF_BITS'(dabs >> front_in.sh);
      lh_in = HALF_BITS'(scale_ff >> front_in.sh);
      case (family_ff)
         FAM_SB: begin
            front_in.ok = diff_pos && right_pos;
            front_in.va = diff[VAL_BITS-1:0];
            front_in.vb = right[VAL_BITS-1:0];
         end
         FAM_SL: begin
            front_in.ok = diff_pos;
            front_in.va = diff[VAL_BITS-1:0];
            front_in.vb = VAL_BITS'(1) << FRAC_BITS;
         end
         FAM_SU: begin
            front_in.ok = (scale_ff != '0);
            front_in.va = dabs[VAL_BITS-1:0];
            front_in.vb = VAL_BITS'(scale_ff);
         end
         default: begin
            front_in.ok = 1'b0;
            front_in.va = diff[VAL_BITS-1:0];
            front_in.vb = right[VAL_BITS-1:0];
         end
      endcase
      if (eta_ff == '0) begin
         front_in.ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= req_sample_in;
         front_ff <= front_in;
         dh_ff <= dh_in;
         lh_ff <= lh_in;
         sqa_ff <= (2*HALF_BITS)'(dh_ff) * (2*HALF_BITS)'(dh_ff);
         sqb_ff <= (2*HALF_BITS)'(lh_ff) * (2*HALF_BITS)'(lh_ff);
         side2_ff <= front_ff;
         sq_st[0].rem <= SQ_BITS'(sqa_ff) + SQ_BITS'(sqb_ff);
         sq_st[0].root <= '0;
         sq_st[0].probe <= SQ_BITS'(1) << (SQ_BITS - 2);
         sq_side[0] <= side2_ff;
      end
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      jft_sqrt_cell u_cell (
         .clock    (clock),
         .en       (en),
         .up_state (sq_st[i]),
         .up_side  (sq_side[i]),
         .dn_state (sq_st[i+1]),
         .dn_side  (sq_side[i+1])
      );
   end

   always_comb begin
      hyp = VAL_BITS'(sq_st[SQRT_STEPS].root[ROOT_BITS-1:0]) << sq_side[SQRT_STEPS].sh;
      va_h_in = is_su ? sq_side[SQRT_STEPS].va + hyp : sq_side[SQRT_STEPS].va;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         va_h_ff <= va_h_in;
         vb_h_ff <= sq_side[SQRT_STEPS].vb;
         h_flag_ff <= {sq_side[SQRT_STEPS].ok, is_su && sq_side[SQRT_STEPS].neg};
         va_n_ff <= va_h_ff;
         vb_n_ff <= vb_h_ff;
         ka_ff <= lead_one(va_h_ff);
         kb_ff <= lead_one(vb_h_ff);
         n_flag_ff <= h_flag_ff;
         log_st[0].lane_a.m <= norm_mant(va_n_ff, ka_ff);
         log_st[0].lane_a.k <= ka_ff;
         log_st[0].lane_a.frac <= '0;
         log_st[0].lane_b.m <= norm_mant(vb_n_ff, kb_ff);
         log_st[0].lane_b.k <= kb_ff;
         log_st[0].lane_b.frac <= '0;
         log_st[0].ok <= n_flag_ff[1];
         log_st[0].neg <= n_flag_ff[0];
      end
   end

   for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
      jft_log_cell u_cell (
         .clock    (clock),
         .en       (en),
         .up_state (log_st[j]),
         .dn_state (log_st[j+1])
      );
   end

   always_comb begin
      la = {log_st[LOG_STEPS].lane_a.k, log_st[LOG_STEPS].lane_a.frac};
      lb = {log_st[LOG_STEPS].lane_b.k, log_st[LOG_STEPS].lane_b.frac};
      a2 = {1'b0, la} - {1'b0, lb};
      if (log_st[LOG_STEPS].neg) begin
         a2 = -a2;
      end
      a2_abs = a2[MAG_BITS] ? -a2 : a2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= a2_abs[MAG_BITS-1:0];
         sgn_ff <= a2[MAG_BITS];
         ok_d_ff <= log_st[LOG_STEPS].ok;
      end
   end

   jft_scale u_scale (
      .clock  (clock),
      .en     (en),
      .mag    (mag_ff),
      .neg    (sgn_ff),
      .ok     (ok_d_ff),
      .gamma  (gamma_ff),
      .eta    (eta_ff),
      .score  (rsp_score_out),
      .status (rsp_status_out)
   );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for johnson_forward_transform: streams samples under many
// curve settings and checks each score and status against an in-bench predictor.
// Depends on jft_pkg and the RTL of the block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jft_pkg::*;

   localparam int MAX_CYCLES = 900000;

   typedef struct {
      logic [31:0] sample;
      logic [31:0] score;
      status_type  status;
   } score_rec_type;

   class score_board;
      family_type         family;
      logic signed [31:0] shift;
      logic [31:0]        scale;
      logic signed [31:0] gamma;
      logic [31:0]        eta;
      score_rec_type      pending_q[$];
      int                 errors;
      int                 checked;

      function new();
         family = FAM_NONE;
         shift = 0;
         scale = 32'd65536;
         gamma = 0;
         eta = 32'd65536;
         errors = 0;
         checked = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] d);
         case (idx)
            CSR_FAMILY: family = family_type'(d[1:0]);
            CSR_SHIFT:  shift = d;
            CSR_SCALE:  scale = d;
            CSR_GAMMA:  gamma = d;
            CSR_ETA:    eta = d;
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH: %s", msg);
      endtask

      function longint log2q(longint unsigned v);
         int k;
         longint unsigned m;
         longint unsigned fr;
         if (v == 0) return 0;
         k = 0;
         while (k < 63 && (v >> (k + 1)) != 0) k++;
         if (k >= LOG_FRAC) m = v >> (k - LOG_FRAC);
         else m = v << (LOG_FRAC - k);
         fr = 0;
         for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> LOG_FRAC;
            fr = fr << 1;
            if (m >= (64'd2 << LOG_FRAC)) begin
               fr = fr | 1;
               m = m >> 1;
            end
         end
         return longint'((64'(k) << LOG_FRAC) | fr);
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned root;
         longint unsigned bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= root + bitv) begin
               n = n - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      endfunction

      function longint unsigned mul_round(longint unsigned a, longint unsigned b, int s);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         p = p + (128'd1 << (s - 1));
         p = p >> s;
         return p[63:0];
      endfunction

      function score_rec_type predict(logic [31:0] sample);
         score_rec_type r;
         longint x, e, l, diff, right, a2, z, prod;
         longint unsigned d, ul, dh, lh, hyp, mag, ln_mag;
         int sh;
         bit ok;
         x = longint'($signed(sample));
         e = longint'(shift);
         l = longint'({32'd0, scale});
         diff = x - e;
         a2 = 0;
         ok = (eta != 0);
         r.sample = sample;
         if (ok && family == FAM_SB) begin
            right = e + l - x;
            ok = diff > 0 && right > 0;
            if (ok) a2 = log2q(diff) - log2q(right);
         end else if (ok && family == FAM_SL) begin
            ok = diff > 0;
            if (ok) a2 = log2q(diff) - (longint'(FRAC_BITS) << LOG_FRAC);
         end else if (ok && family == FAM_SU) begin
            ok = l > 0;
            if (ok) begin
               d = diff < 0 ? -diff : diff;
               ul = l;
               sh = (d >= 64'h8000_0000 || ul >= 64'h8000_0000) ? 1 : 0;
               dh = d >> sh;
               lh = ul >> sh;
               hyp = int_sqrt(dh * dh + lh * lh) << sh;
               a2 = log2q(d + hyp) - log2q(ul);
               if (diff < 0) a2 = -a2;
            end
         end else begin
            ok = 0;
         end
         if (!ok) begin
            r.score = 0;
            r.status = STAT_RANGE;
            return r;
         end
         mag = a2 < 0 ? -a2 : a2;
         ln_mag = mul_round(mag, {32'd0, LN2_Q32}, 32);
         prod = longint'(mul_round(ln_mag, {32'd0, eta}, LOG_FRAC));
         z = longint'(gamma) + (a2 < 0 ? -prod : prod);
         r.status = STAT_OK;
         if (z > 64'sd2147483647) begin
            z = 64'sd2147483647;
            r.status = STAT_SAT;
         end else if (z < -64'sd2147483648) begin
            z = -64'sd2147483648;
            r.status = STAT_SAT;
         end
         r.score = z[31:0];
         return r;
      endfunction

      function void note_request(logic [31:0] sample);
         pending_q = {pending_q, predict(sample)};
      endfunction

      task check_response(logic [31:0] score, logic [1:0] status);
         score_rec_type r;
         checked++;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected response score %h status %0d", score, status));
         end else begin
            r = pending_q.pop_front();
            if (score !== r.score || status !== r.status)
               report($sformatf("sample %h: score %h status %0d, want %h status %0d",
                                r.sample, score, status, r.score, r.status));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_sample_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_score_out;
   logic [1:0]  rsp_status_out;
   logic        csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [31:0] csr_wdata;

   score_board sb;
   int          cycles;
   int          n_sent;
   int          burst_left;
   int          n_phases;
   bit          valid_on;

   johnson_forward_transform u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_score_out(rsp_score_out), .rsp_status_out(rsp_status_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_sample_in);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_score_out, rsp_status_out);
      end
   end

   initial begin
      int mode;
      int left;
      int stall;
      mode = 0;
      left = 0;
      stall = 0;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(50, 300);
         end
         left--;
         case (mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: begin
               if (stall == 0) begin
                  stall = $urandom_range(1, 15);
                  rsp_ready <= 1;
               end else begin
                  stall--;
                  rsp_ready <= 0;
               end
            end
         endcase
      end
   end

   task write_csr(csr_index_type idx, logic [31:0] d);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= d;
      sb.set_reg(idx, d);
      @(posedge clock);
   endtask

   task drain();
      if (valid_on) req_valid <= 0;
      valid_on = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task send_sample(logic [31:0] s);
      bit got;
      req_valid <= 1;
      req_sample_in <= s;
      valid_on = 1;
      do begin
         @(negedge clock);
         got = req_ready;
         @(posedge clock);
      end while (!got);
      n_sent++;
      if (burst_left == 0) begin
         req_valid <= 0;
         valid_on = 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 1) ? $urandom_range(1, 10) : $urandom_range(30, 120);
      end else begin
         burst_left--;
      end
   endtask

   task set_curve(family_type f, logic [31:0] e, logic [31:0] l, logic [31:0] g,
                  logic [31:0] h);
      drain();
      write_csr(CSR_FAMILY, f);
      write_csr(CSR_SHIFT, e);
      write_csr(CSR_SCALE, l);
      write_csr(CSR_GAMMA, g);
      write_csr(CSR_ETA, h);
      csr_we <= 0;
      n_phases++;
   endtask

   function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647 || v < -64'sd2147483648) return $urandom;
      return v[31:0];
   endfunction

   function logic [31:0] pick_sample();
      longint e, l;
      int sel;
      e = longint'(sb.shift);
      l = longint'({32'd0, sb.scale});
      sel = $urandom_range(0, 9);
      if (sel < 2) return $urandom;
      if (sel == 2) begin
         case ($urandom_range(0, 5))
            0: return clamp32(e);
            1: return clamp32(e + 1);
            2: return clamp32(e + l - 1);
            3: return clamp32(e + l);
            4: return 32'h8000_0000;
            default: return 32'h7fff_ffff;
         endcase
      end
      case (sb.family)
         FAM_SB: if (l > 1) return clamp32(e + 1 + ($urandom % (l - 1)));
         FAM_SL: return clamp32(e + 1 + $urandom_range(0, 32'h00ff_ffff));
         default: ;
      endcase
      return clamp32(e + longint'($signed(32'($urandom_range(0, 32'h01ff_ffff)))) -
                     longint'(32'h0100_0000));
   endfunction

   initial begin
      logic [31:0] rs, rl, rg, rh;
      sb = new();
      cycles = 0;
      n_sent = 0;
      n_phases = 0;
      burst_left = 20;
      valid_on = 0;
      reset = 1;
      req_valid = 0;
      req_sample_in = 0;
      csr_we = 0;
      csr_index = CSR_FAMILY;
      csr_wdata = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_sample(32'h8000_0000);
      send_sample(32'h7fff_ffff);
      send_sample(0);
      set_curve(FAM_SB, 0, 32'h0004_0000, 0, 32'h0001_0000);
      send_sample(0);
      send_sample(1);
      send_sample(32'h0002_0000);
      send_sample(32'h0003_ffff);
      send_sample(32'h0004_0000);
      set_curve(FAM_SL, 32'hffff_0000, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
      send_sample(32'hffff_0000);
      send_sample(32'hffff_0001);
      send_sample(32'h7fff_ffff);
      set_curve(FAM_SU, 32'h0001_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0001_0000);
      send_sample(32'h8000_0000);
      send_sample(32'h7fff_ffff);
      send_sample(32'h0001_0000);
      set_curve(FAM_SU, 0, 0, 0, 32'h0001_0000);
      send_sample(32'h0000_1234);
      set_curve(FAM_SL, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff, 32'hffff_ffff);
      send_sample(32'h7fff_ffff);
      send_sample(32'h8000_0001);
      set_curve(FAM_SB, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff);
      send_sample(32'h8000_0001);
      send_sample(32'h7fff_fffe);
      set_curve(FAM_SB, 0, 32'h0001_0000, 0, 0);
      send_sample(32'h0000_8000);

      for (int p = 0; p < 14; p++) begin
         case ($urandom_range(0, 3))
            0: rs = 0;
            1: rs = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: rs = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0: rl = 32'hffff_ffff;
            1: rl = $urandom_range(1, 4);
            2: rl = $urandom;
            default: rl = $urandom_range(32'h0000_1000, 32'h0100_0000);
         endcase
         case ($urandom_range(0, 3))
            0: rg = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1: rg = $urandom;
            default: rg = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         endcase
         case ($urandom_range(0, 5))
            0: rh = 0;
            1: rh = 32'hffff_ffff;
            2: rh = $urandom;
            default: rh = $urandom_range(32'h0000_4000, 32'h0004_0000);
         endcase
         set_curve(family_type'(p % 4), rs, rl, rg, rh);
         for (int i = 0; i < 80; i++) send_sample(pick_sample());
      end

      drain();
      repeat (100) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d responses never came", sb.pending()));
      $display("Covered %0d samples over %0d curve settings, %0d responses checked.",
               n_sent, n_phases, sb.checked);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ===== johnson_forward_transform.f =====
rtl/jft_pkg.sv
rtl/jft_sqrt_cell.sv
rtl/jft_log_cell.sv
rtl/jft_scale.sv
rtl/johnson_forward_transform.sv
bench/tb.sv
